FILE: rtl/tsd_pkg.sv
package tsd_pkg;

    // Field widths of the byte stream and of the result word.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned TOTAL_W = 34;
    localparam int unsigned ITEMS_W = 32;
    localparam int unsigned LEFT_W  = 3;
    localparam int unsigned CFG_IDX_W = 3;

    // Result status codes.
    localparam logic [STAT_W-1:0] STATUS_BUSY = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ERR  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_EMIT_CHARS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_STRING    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_LIST      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_SMALL_INT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_NIL       = 3'd4;

    // Reset values of the tag registers, from the published format.
    localparam logic [BYTE_W-1:0] RST_TAG_STRING    = 8'd107;
    localparam logic [BYTE_W-1:0] RST_TAG_LIST      = 8'd108;
    localparam logic [BYTE_W-1:0] RST_TAG_SMALL_INT = 8'd97;
    localparam logic [BYTE_W-1:0] RST_TAG_NIL       = 8'd106;

    // Number of length bytes after each header tag.
    localparam logic [LEFT_W-1:0] STR_LEN_BYTES = 3'd2;
    localparam logic [LEFT_W-1:0] LST_LEN_BYTES = 3'd4;

    // One result word.
    typedef struct packed {
        logic [BYTE_W-1:0]  out_char;
        logic               char_valid;
        logic [STAT_W-1:0]  status;
        logic [TOTAL_W-1:0] bytes_consumed;
    } t_out_word;

endpackage

FILE: rtl/tsd_if.sv
// Input byte channel.
interface tsd_in_if import tsd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// Result channel.
interface tsd_out_if import tsd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [BYTE_W-1:0]  out_char;
    logic               char_valid;
    logic [STAT_W-1:0]  status;
    logic [TOTAL_W-1:0] bytes_consumed;

    modport source (output valid, output out_char, output char_valid, output status,
                    output bytes_consumed, input ready);
    modport sink   (input valid, input out_char, input char_valid, input status,
                    input bytes_consumed, output ready);
endinterface

// Configuration write channel.
interface tsd_cfg_if import tsd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/term_string_decoder.sv
// A byte accepted into the input register has its result word loaded into the result
// register as soon as the result register is empty or being drained.
// One byte per cycle unless a result word waits; an empty input register fills even then.
// A byte that yields no result word leaves the output side free in that cycle.
// Reset (synchronous, active low) returns the decoder to idle, empties both
// registers and restores the register defaults (emit on, standard tag codes).
module term_string_decoder import tsd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    tsd_in_if.sink       i_in,
    tsd_out_if.source    o_out,
    tsd_cfg_if.sink      i_cfg
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR_LEN,
        PH_STR_CHR,
        PH_LST_LEN,
        PH_LST_TAG,
        PH_LST_VAL,
        PH_LST_NIL
    } t_phase;

    // Configuration registers.
    logic              r_emit_chars;
    logic [BYTE_W-1:0] r_tag_string;
    logic [BYTE_W-1:0] r_tag_list;
    logic [BYTE_W-1:0] r_tag_small_int;
    logic [BYTE_W-1:0] r_tag_nil;

    // Input register.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Decoder state.
    t_phase             r_phase,     n_phase;
    logic [LEFT_W-1:0]  r_len_left,  n_len_left;
    logic [ITEMS_W-1:0] r_items,     n_items;
    logic [TOTAL_W-1:0] r_total,     n_total;

    // Result register.
    logic      r_out_valid;
    t_out_word r_out, n_out;
    logic      n_res;

    logic               w_adv;
    logic               w_in_acc;
    logic [TOTAL_W-1:0] w_total;
    logic [ITEMS_W-1:0] w_items_shift;
    logic [ITEMS_W-1:0] w_items_dec;
    logic [LEFT_W-1:0]  w_len_dec;
    logic [BYTE_W-1:0]  w_b;

    // The result register can take a new word when it is empty or being drained.
    assign w_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = w_adv || !r_in_valid;
    assign w_in_acc  = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid          = r_out_valid;
    assign o_out.out_char       = r_out.out_char;
    assign o_out.char_valid     = r_out.char_valid;
    assign o_out.status         = r_out.status;
    assign o_out.bytes_consumed = r_out.bytes_consumed;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit_chars    <= 1'b1;
            r_tag_string    <= RST_TAG_STRING;
            r_tag_list      <= RST_TAG_LIST;
            r_tag_small_int <= RST_TAG_SMALL_INT;
            r_tag_nil       <= RST_TAG_NIL;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_EMIT_CHARS:    r_emit_chars    <= i_cfg.data[0];
                CFG_TAG_STRING:    r_tag_string    <= i_cfg.data;
                CFG_TAG_LIST:      r_tag_list      <= i_cfg.data;
                CFG_TAG_SMALL_INT: r_tag_small_int <= i_cfg.data;
                CFG_TAG_NIL:       r_tag_nil       <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input register loads whenever it is free or moving on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= w_in_acc;
        end
        if (w_in_acc) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    assign w_b           = r_in_byte;
    assign w_total       = r_total + TOTAL_W'(1);
    assign w_items_shift = {r_items[ITEMS_W-BYTE_W-1:0], w_b};
    assign w_items_dec   = r_items - ITEMS_W'(1);
    assign w_len_dec     = r_len_left - LEFT_W'(1);

    // Next state and result word for the byte in the input register.
    always_comb begin
        n_phase    = r_phase;
        n_len_left = r_len_left;
        n_items    = r_items;
        n_total    = w_total;
        n_res      = 1'b0;
        n_out      = '0;
        case (r_phase)
            PH_IDLE: begin
                if (w_b == r_tag_string) begin
                    n_phase    = PH_STR_LEN;
                    n_len_left = STR_LEN_BYTES;
                    n_items    = '0;
                end else if (w_b == r_tag_list) begin
                    n_phase    = PH_LST_LEN;
                    n_len_left = LST_LEN_BYTES;
                    n_items    = '0;
                end else begin
                    n_phase    = PH_IDLE;
                    n_len_left = '0;
                    n_items    = '0;
                    n_total    = '0;
                    n_res      = 1'b1;
                    if (w_b == r_tag_nil) begin
                        n_out.status         = STATUS_OK;
                        n_out.bytes_consumed = w_total;
                    end else begin
                        n_out.status = STATUS_ERR;
                    end
                end
            end
            PH_STR_LEN: begin
                n_items    = w_items_shift;
                n_len_left = w_len_dec;
                if (w_len_dec == '0) begin
                    if (w_items_shift == '0) begin
                        n_phase              = PH_IDLE;
                        n_items              = '0;
                        n_total              = '0;
                        n_res                = 1'b1;
                        n_out.status         = STATUS_OK;
                        n_out.bytes_consumed = w_total;
                    end else begin
                        n_phase = PH_STR_CHR;
                    end
                end
            end
            PH_STR_CHR: begin
                n_items = w_items_dec;
                if (r_emit_chars) begin
                    n_res            = 1'b1;
                    n_out.out_char   = w_b;
                    n_out.char_valid = 1'b1;
                end
                if (w_items_dec == '0) begin
                    n_phase              = PH_IDLE;
                    n_len_left           = '0;
                    n_total              = '0;
                    n_res                = 1'b1;
                    n_out.status         = STATUS_OK;
                    n_out.bytes_consumed = w_total;
                end
            end
            PH_LST_LEN: begin
                n_items    = w_items_shift;
                n_len_left = w_len_dec;
                if (w_len_dec == '0) begin
                    n_phase = (w_items_shift == '0) ? PH_LST_NIL : PH_LST_TAG;
                end
            end
            PH_LST_TAG: begin
                if (w_b != r_tag_small_int) begin
                    n_phase      = PH_IDLE;
                    n_len_left   = '0;
                    n_items      = '0;
                    n_total      = '0;
                    n_res        = 1'b1;
                    n_out.status = STATUS_ERR;
                end else begin
                    n_phase = PH_LST_VAL;
                end
            end
            PH_LST_VAL: begin
                n_items = w_items_dec;
                n_phase = (w_items_dec == '0) ? PH_LST_NIL : PH_LST_TAG;
                if (r_emit_chars) begin
                    n_res            = 1'b1;
                    n_out.out_char   = w_b;
                    n_out.char_valid = 1'b1;
                end
            end
            PH_LST_NIL: begin
                n_phase    = PH_IDLE;
                n_len_left = '0;
                n_items    = '0;
                n_total    = '0;
                n_res      = 1'b1;
                if (w_b != r_tag_nil) begin
                    n_out.status = STATUS_ERR;
                end else begin
                    n_out.status         = STATUS_OK;
                    n_out.bytes_consumed = w_total;
                end
            end
            default: begin
                n_phase    = PH_IDLE;
                n_len_left = '0;
                n_items    = '0;
                n_total    = '0;
            end
        endcase
    end

    // State and result register advance together when the output side is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_len_left  <= '0;
            r_items     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid && n_res;
            if (r_in_valid) begin
                r_phase    <= n_phase;
                r_len_left <= n_len_left;
                r_items    <= n_items;
                r_total    <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_in_valid && n_res) begin
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    // Idle always means a fresh term: no count and no items carried over.
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_total == '0 && r_items == '0))
        else $error("decoder idle with leftover term state");

    // A byte count is reported only with a successful finish.
    a_count_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != STATUS_OK) |-> (r_out.bytes_consumed == '0))
        else $error("byte count given without ok status");

    // A finished term has consumed at least its tag byte.
    a_ok_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STATUS_OK) |-> (r_out.bytes_consumed != '0))
        else $error("ok status with zero byte count");

    // An error word never carries a character.
    a_err_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == STATUS_ERR) |-> !r_out.char_valid)
        else $error("error word carries a character");

    // A word that is held back keeps a full input register full.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready && r_in_valid) |=> r_in_valid)
        else $error("pending byte dropped during output stall");
`endif

endmodule

FILE: dv/tb_term_string_decoder.sv
`timescale 1ns / 100ps

module tb_term_string_decoder import tsd_pkg::*; ();

    localparam int unsigned CYCLE_LIMIT = 4000000;
    localparam int unsigned SETTLE_CYCLES = 8;

    // Decoder phases of the shadow decoder.
    typedef enum logic [2:0] {
        DEC_IDLE,
        DEC_STR_LEN,
        DEC_STR_CHR,
        DEC_LST_LEN,
        DEC_LST_TAG,
        DEC_LST_VAL,
        DEC_LST_NIL
    } t_dec_phase;

    logic i_clk;
    logic i_rst_n;

    tsd_in_if  in_if ();
    tsd_out_if out_if ();
    tsd_cfg_if cfg_if ();

    term_string_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // Shadow copy of the register file.
    logic              cfg_emit;
    logic [BYTE_W-1:0] cfg_tag_str;
    logic [BYTE_W-1:0] cfg_tag_list;
    logic [BYTE_W-1:0] cfg_tag_small;
    logic [BYTE_W-1:0] cfg_tag_nil;

    // Shadow decoder state.
    t_dec_phase         dec_phase;
    logic [LEFT_W-1:0]  len_left;
    logic [ITEMS_W-1:0] items_left;
    logic [TOTAL_W-1:0] term_bytes;

    // Encoded bytes waiting to be sent and decoded words still owed by the block.
    logic [BYTE_W-1:0] byte_q[$];
    t_out_word         word_q[$];

    int unsigned pending_bytes;
    int unsigned pushed;
    int unsigned fail_count;
    int unsigned cycles;
    int unsigned send_wait;
    int unsigned recv_wait;
    int unsigned hold_left;
    bit          idle_on;
    bit          byte_taken;
    bit          word_taken;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned draw_wait();
        return idle_on ? $urandom_range(0, 9) : 0;
    endfunction

    // Advance the shadow decoder by one byte and queue the word it owes, if any.
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        t_out_word w;
        bit        has_word;
        bit        done;
        w = '0;
        has_word = 1'b0;
        done = 1'b0;
        term_bytes = term_bytes + 1'b1;
        case (dec_phase)
            DEC_IDLE: begin
                if (b == cfg_tag_str) begin
                    dec_phase = DEC_STR_LEN;
                    len_left = STR_LEN_BYTES;
                    items_left = '0;
                end else if (b == cfg_tag_list) begin
                    dec_phase = DEC_LST_LEN;
                    len_left = LST_LEN_BYTES;
                    items_left = '0;
                end else if (b == cfg_tag_nil) begin
                    has_word = 1'b1;
                    done = 1'b1;
                    w.status = STATUS_OK;
                    w.bytes_consumed = term_bytes;
                end else begin
                    has_word = 1'b1;
                    done = 1'b1;
                    w.status = STATUS_ERR;
                end
            end
            DEC_STR_LEN: begin
                items_left = {items_left[ITEMS_W-9:0], b};
                len_left = len_left - 1'b1;
                if (len_left == 0) begin
                    if (items_left == 0) begin
                        has_word = 1'b1;
                        done = 1'b1;
                        w.status = STATUS_OK;
                        w.bytes_consumed = term_bytes;
                    end else begin
                        dec_phase = DEC_STR_CHR;
                    end
                end
            end
            DEC_STR_CHR: begin
                items_left = items_left - 1'b1;
                if (items_left == 0) begin
                    // The last character and the completion share one word.
                    has_word = 1'b1;
                    done = 1'b1;
                    w.status = STATUS_OK;
                    w.bytes_consumed = term_bytes;
                    if (cfg_emit) begin
                        w.out_char = b;
                        w.char_valid = 1'b1;
                    end
                end else if (cfg_emit) begin
                    has_word = 1'b1;
                    w.out_char = b;
                    w.char_valid = 1'b1;
                end
            end
            DEC_LST_LEN: begin
                items_left = {items_left[ITEMS_W-9:0], b};
                len_left = len_left - 1'b1;
                if (len_left == 0) begin
                    dec_phase = (items_left == 0) ? DEC_LST_NIL : DEC_LST_TAG;
                end
            end
            DEC_LST_TAG: begin
                if (b != cfg_tag_small) begin
                    has_word = 1'b1;
                    done = 1'b1;
                    w.status = STATUS_ERR;
                end else begin
                    dec_phase = DEC_LST_VAL;
                end
            end
            DEC_LST_VAL: begin
                items_left = items_left - 1'b1;
                dec_phase = (items_left == 0) ? DEC_LST_NIL : DEC_LST_TAG;
                if (cfg_emit) begin
                    has_word = 1'b1;
                    w.out_char = b;
                    w.char_valid = 1'b1;
                end
            end
            DEC_LST_NIL: begin
                has_word = 1'b1;
                done = 1'b1;
                if (b != cfg_tag_nil) begin
                    w.status = STATUS_ERR;
                end else begin
                    w.status = STATUS_OK;
                    w.bytes_consumed = term_bytes;
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
        if (done) begin
            dec_phase = DEC_IDLE;
            len_left = '0;
            items_left = '0;
            term_bytes = '0;
        end
        if (has_word) begin
            word_q.push_back(w);
        end
    endfunction

    // Byte sender: holds each byte until taken, then waits its drawn gap.
    always @(negedge i_clk) begin
        if (!in_if.valid || byte_taken) begin
            if (send_wait > 0) begin
                send_wait--;
                in_if.valid <= 1'b0;
            end else if (byte_q.size() != 0) begin
                in_if.in_byte <= byte_q.pop_front();
                in_if.valid <= 1'b1;
                send_wait = draw_wait();
            end else begin
                in_if.valid <= 1'b0;
            end
        end
        byte_taken = 1'b0;
    end

    // Word receiver: a drawn stall after each word, plus an optional long hold-off.
    always @(negedge i_clk) begin
        if (word_taken) begin
            recv_wait = draw_wait();
            word_taken = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (recv_wait > 0) begin
            recv_wait--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // Monitor: predict on each accepted byte, check each accepted word.
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                byte_taken = 1'b1;
                pending_bytes--;
                decode_byte(in_if.in_byte);
            end
            if (out_if.valid && out_if.ready) begin
                word_taken = 1'b1;
                got.out_char = out_if.out_char;
                got.char_valid = out_if.char_valid;
                got.status = out_if.status;
                got.bytes_consumed = out_if.bytes_consumed;
                if (word_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected word, expected none, got %h", $realtime, got);
                end else begin
                    want = word_q.pop_front();
                    if (got.out_char !== want.out_char || got.char_valid !== want.char_valid
                        || got.status !== want.status
                        || got.bytes_consumed !== want.bytes_consumed) begin
                        fail_count++;
                        $display("%0t: word mismatch, expected %h, got %h",
                                 $realtime, want, got);
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        byte_q.push_back(b);
        pending_bytes++;
        pushed++;
    endtask

    // Draws a byte that matches none of the three given codes.
    function automatic logic [BYTE_W-1:0] other_than(input logic [BYTE_W-1:0] a,
                                                      input logic [BYTE_W-1:0] b,
                                                      input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] v;
        do begin
            v = $urandom_range(0, 255);
        end while (v == a || v == b || v == c);
        return v;
    endfunction

    task automatic add_nil_term();
        push_byte(cfg_tag_nil);
    endtask

    task automatic add_bad_head();
        push_byte(other_than(cfg_tag_str, cfg_tag_list, cfg_tag_nil));
    endtask

    task automatic add_string_term(input int unsigned len);
        logic [15:0] len16;
        len16 = len;
        push_byte(cfg_tag_str);
        push_byte(len16[15:8]);
        push_byte(len16[7:0]);
        for (int unsigned i = 0; i < len; i++) begin
            push_byte($urandom_range(0, 255));
        end
    endtask

    // A list term; bad_at below count breaks that element's tag, bad_at equal
    // to count breaks the tail, and a negative bad_at keeps the term well formed.
    task automatic add_list_term(input logic [31:0] count, input longint bad_at);
        longint n;
        bit     bad_elem;
        bad_elem = (bad_at >= 0) && (bad_at < longint'(count));
        n = bad_elem ? bad_at : longint'(count);
        push_byte(cfg_tag_list);
        push_byte(count[31:24]);
        push_byte(count[23:16]);
        push_byte(count[15:8]);
        push_byte(count[7:0]);
        for (longint i = 0; i < n; i++) begin
            push_byte(cfg_tag_small);
            push_byte($urandom_range(0, 255));
        end
        if (bad_elem) begin
            push_byte(other_than(cfg_tag_small, cfg_tag_small, cfg_tag_small));
        end else if (bad_at >= 0) begin
            push_byte(other_than(cfg_tag_nil, cfg_tag_nil, cfg_tag_nil));
        end else begin
            push_byte(cfg_tag_nil);
        end
    endtask

    // Mostly well-formed terms with random content, the rest broken ones.
    // Every term ends with the decoder back in idle.
    task automatic add_random_term();
        int unsigned pick;
        int unsigned n;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 60) : $urandom_range(0, 10);
            add_string_term(n);
        end else if (pick < 62) begin
            add_list_term($urandom_range(0, 8), -1);
        end else if (pick < 70) begin
            add_nil_term();
        end else if (pick < 78) begin
            add_bad_head();
        end else if (pick < 88) begin
            n = $urandom_range(1, 6);
            add_list_term(n, $urandom_range(0, n - 1));
        end else if (pick < 95) begin
            n = $urandom_range(0, 5);
            add_list_term(n, n);
        end else begin
            add_list_term($urandom | 32'h100, $urandom_range(0, 3));
        end
    endtask

    task automatic add_random_bytes(input int unsigned n_bytes);
        int unsigned goal;
        goal = pushed + n_bytes;
        while (pushed < goal) begin
            add_random_term();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] val);
        @(negedge i_clk);
        cfg_if.index <= idx;
        cfg_if.data <= val;
        cfg_if.valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        case (idx)
            CFG_EMIT_CHARS:    cfg_emit = val[0];
            CFG_TAG_STRING:    cfg_tag_str = val;
            CFG_TAG_LIST:      cfg_tag_list = val;
            CFG_TAG_SMALL_INT: cfg_tag_small = val;
            CFG_TAG_NIL:       cfg_tag_nil = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic set_config(input logic emit, input logic [BYTE_W-1:0] t_str,
                              input logic [BYTE_W-1:0] t_list, input logic [BYTE_W-1:0] t_small,
                              input logic [BYTE_W-1:0] t_nil);
        write_reg(CFG_EMIT_CHARS, {7'd0, emit});
        write_reg(CFG_TAG_STRING, t_str);
        write_reg(CFG_TAG_LIST, t_list);
        write_reg(CFG_TAG_SMALL_INT, t_small);
        write_reg(CFG_TAG_NIL, t_nil);
    endtask

    // Standard tags now and then, otherwise distinct random header tags.
    task automatic random_config();
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] l;
        logic [BYTE_W-1:0] n;
        if ($urandom_range(0, 3) == 0) begin
            set_config($urandom_range(0, 1), RST_TAG_STRING, RST_TAG_LIST, RST_TAG_SMALL_INT,
                       RST_TAG_NIL);
        end else begin
            s = $urandom_range(0, 255);
            l = other_than(s, s, s);
            n = other_than(s, l, l);
            set_config($urandom_range(0, 1), s, l, $urandom_range(0, 255), n);
        end
    endtask

    // Waits until every byte is taken and every owed word has arrived, then
    // lets bytes that owe no word clear the pipeline.
    task automatic wait_drained();
        while (pending_bytes != 0 || word_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        out_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        cfg_emit = 1'b1;
        cfg_tag_str = RST_TAG_STRING;
        cfg_tag_list = RST_TAG_LIST;
        cfg_tag_small = RST_TAG_SMALL_INT;
        cfg_tag_nil = RST_TAG_NIL;
        dec_phase = DEC_IDLE;
        len_left = '0;
        items_left = '0;
        term_bytes = '0;
        pending_bytes = 0;
        pushed = 0;
        fail_count = 0;
        cycles = 0;
        send_wait = 0;
        recv_wait = 0;
        hold_left = 0;
        idle_on = 1'b0;
        byte_taken = 1'b0;
        word_taken = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed terms under the reset register values.
        add_nil_term();
        add_string_term(0);
        push_byte(cfg_tag_str);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hFF);
        add_list_term(0, -1);
        push_byte(cfg_tag_list);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(cfg_tag_small);
        push_byte(8'h00);
        push_byte(cfg_tag_nil);
        add_bad_head();
        add_list_term(32'hFFFF_FFFF, 0);
        add_list_term(0, 0);
        wait_drained();

        // Extreme tag codes with character output off, then on.
        idle_on = 1'b1;
        set_config(1'b0, 8'h00, 8'hFF, 8'h00, 8'h80);
        add_random_bytes(60);
        wait_drained();
        set_config(1'b1, 8'hFF, 8'h00, 8'hFF, 8'h01);
        add_random_bytes(60);
        wait_drained();

        // Random settings; one phase holds off the receiver while bytes keep coming.
        for (int k = 0; k < 10; k++) begin
            idle_on = (k % 3) != 2;
            if (k == 3) begin
                idle_on = 1'b0;
                set_config(1'b1, RST_TAG_STRING, RST_TAG_LIST, RST_TAG_SMALL_INT, RST_TAG_NIL);
                @(posedge i_clk);
                hold_left = 200;
                add_string_term(30);
                add_list_term(20, -1);
            end else begin
                random_config();
            end
            add_random_bytes(80);
            wait_drained();
        end

        // One string with both length bytes in use, validated and counted only.
        idle_on = 1'b0;
        set_config(1'b0, RST_TAG_STRING, RST_TAG_LIST, RST_TAG_SMALL_INT, RST_TAG_NIL);
        add_string_term(16'h0103);
        wait_drained();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && word_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
